### rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and helper functions for the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUND_W = 7;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Register word index taken from the APB byte address.
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4,
    REG_SWAP   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_e;

  typedef logic [3:0][WORD_W-1:0] key_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    key_t               key;
    logic [ROUND_W-1:0] rounds;
    logic               swap;
  } cfg_t;

  function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // One TEA mixing term.
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] w,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] kl,
                                                input logic [WORD_W-1:0] kr);
    return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
  endfunction

endpackage

### rtl/tea_cfg.sv
// ----------------------------------------------------------------------------
// tea_cfg
// APB register file holding the key, the round count and the swap flag.
// ----------------------------------------------------------------------------
module tea_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [tea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output tea_pkg::cfg_t          cfg_o
);
  import tea_pkg::*;

  key_t               key_q;
  logic [ROUND_W-1:0] rounds_q;
  logic               swap_q;
  reg_idx_e           idx;
  logic               wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= ROUND_W'(32);
      swap_q   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_KEY0:   key_q[0] <= pwdata;
        REG_KEY1:   key_q[1] <= pwdata;
        REG_KEY2:   key_q[2] <= pwdata;
        REG_KEY3:   key_q[3] <= pwdata;
        REG_ROUNDS: rounds_q <= pwdata[ROUND_W-1:0];
        REG_SWAP:   swap_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY0:   prdata = key_q[0];
      REG_KEY1:   prdata = key_q[1];
      REG_KEY2:   prdata = key_q[2];
      REG_KEY3:   prdata = key_q[3];
      REG_ROUNDS: prdata = {{(32-ROUND_W){1'b0}}, rounds_q};
      REG_SWAP:   prdata = {31'd0, swap_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{key: key_q, rounds: rounds_q, swap: swap_q};

endmodule

### rtl/tea_round.sv
// ----------------------------------------------------------------------------
// tea_round
// Shared round unit: one full TEA cycle, forward or backward.
// ----------------------------------------------------------------------------
module tea_round (
  input  logic                        decrypt_i,
  input  logic [tea_pkg::WORD_W-1:0]  y_i,
  input  logic [tea_pkg::WORD_W-1:0]  z_i,
  input  logic [tea_pkg::WORD_W-1:0]  sum_i,
  input  tea_pkg::key_t               key_i,
  output logic [tea_pkg::WORD_W-1:0]  y_o,
  output logic [tea_pkg::WORD_W-1:0]  z_o,
  output logic [tea_pkg::WORD_W-1:0]  sum_o
);
  import tea_pkg::*;

  logic [WORD_W-1:0] sum_enc;
  logic [WORD_W-1:0] y_enc;
  logic [WORD_W-1:0] z_dec;

  always_comb begin
    sum_enc = sum_i + TEA_DELTA;
    y_enc   = y_i + tea_mix(z_i, sum_enc, key_i[0], key_i[1]);
    z_dec   = z_i - tea_mix(y_i, sum_i, key_i[2], key_i[3]);
    if (decrypt_i) begin
      // Backward cycle: z first with the current sum, then y.
      z_o   = z_dec;
      y_o   = y_i - tea_mix(z_dec, sum_i, key_i[0], key_i[1]);
      sum_o = sum_i - TEA_DELTA;
    end else begin
      y_o   = y_enc;
      z_o   = z_i + tea_mix(y_enc, sum_enc, key_i[2], key_i[3]);
      sum_o = sum_enc;
    end
  end

endmodule

### rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt of one 64-bit block with an APB configuration port.
// ----------------------------------------------------------------------------
// Flow: a block is loaded into the working registers in IDLE, stepped
// through its rounds in RUN, then written into the result register once that
// register is free, so a stalled output holds the sequencer in RUN. No new
// block is taken until the last one has left RUN. The single shared round
// unit performs one TEA cycle per clock. Reset is async, active low, and
// returns key 0, round count 32 and a clear swap flag.
// ----------------------------------------------------------------------------
module tea_block_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tea_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [31:0]                 block_word0_i,
  input  logic [31:0]                 block_word1_i,
  input  logic [3:0]                  valid_bytes_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 result_word0_o,
  output logic [31:0]                 result_word1_o
);
  import tea_pkg::*;

  cfg_t               cfg;
  key_t               key_use;
  seq_state_e         state_q, state_d;
  logic [ROUND_W-1:0] cnt_q;
  logic [WORD_W-1:0]  y_q, z_q, sum_q;
  logic               dec_q, swap_q;
  logic [WORD_W-1:0]  y_nxt, z_nxt, sum_nxt;
  logic [WORD_W-1:0]  res0_q, res1_q;
  logic               out_valid_q, out_valid_d;
  logic               load, step, finish;
  logic               full_blk, swap_in;
  logic [WORD_W-1:0]  dec_start;

  tea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Key words are byte-reversed on the fly and no copy is kept; the user must keep
  // the configuration stable while an item is in flight, as the block does not enforce it.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_use[i] = cfg.swap ? bswap32(cfg.key[i]) : cfg.key[i];
    end
  end

  tea_round u_round (
    .decrypt_i (dec_q),
    .y_i       (y_q),
    .z_i       (z_q),
    .sum_i     (sum_q),
    .key_i     (key_use),
    .y_o       (y_nxt),
    .z_o       (z_nxt),
    .sum_o     (sum_nxt)
  );

  // A block with fewer than eight valid bytes is loaded with no rounds and
  // no byte swap, so it leaves exactly as it came in.
  assign full_blk  = valid_bytes_i[3];
  assign swap_in   = cfg.swap && full_blk;
  // Decryption starts from delta times the round count, modulo 2^32.
  assign dec_start = 32'(TEA_DELTA * {{(WORD_W-ROUND_W){1'b0}}, cfg.rounds});

  // Sequencer: accept in IDLE, iterate in RUN, and hand the result to the
  // output register once the rounds are done and that register is free.
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load    = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q != '0) begin
          step = 1'b1;
        end else if (!out_valid_q || !out_stall_i) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        cnt_q <= full_blk ? cfg.rounds : '0;
      end else if (step) begin
        cnt_q <= cnt_q - ROUND_W'(1);
      end
    end
  end

  // Working registers of the block in flight and the result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      y_q    <= swap_in ? bswap32(block_word0_i) : block_word0_i;
      z_q    <= swap_in ? bswap32(block_word1_i) : block_word1_i;
      sum_q  <= (full_blk && req_type_i) ? dec_start : '0;
      dec_q  <= req_type_i;
      swap_q <= swap_in;
    end else if (step) begin
      y_q   <= y_nxt;
      z_q   <= z_nxt;
      sum_q <= sum_nxt;
    end
    if (finish) begin
      res0_q <= swap_q ? bswap32(y_q) : y_q;
      res1_q <= swap_q ? bswap32(z_q) : z_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_word0_o = res0_q;
  assign result_word1_o = res1_q;

  // A transfer on the input always starts a run.
  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN)
    else $error("accepted block did not start a run");

  // The round counter goes down by exactly one per round.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && cnt_q != '0 |=> cnt_q == $past(cnt_q) - ROUND_W'(1))
    else $error("round counter skipped");

  // A decryption run unwinds the sum back to zero.
  a_dec_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && cnt_q == '0 && dec_q |-> sum_q == '0)
    else $error("decrypt sum did not return to zero");

  // A new result only appears when a run completes.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RUN && cnt_q == '0))
    else $error("result valid without a finished run");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the TEA block cipher.
// ----------------------------------------------------------------------------
// A driver process offers 64-bit blocks on the input channel. A monitor
// process compares each result transfer with a TEA model kept in this file.
// The run starts with a short directed set: reset values, extreme words,
// short and oversized byte counts, zero and maximum round counts, and both
// byte orders. Then about 1600 random blocks follow across many key and round
// settings. Each setting is paired with one of four idling patterns on the
// two channels, in rotation. In one setting the output is held off for a long
// stretch, so that the cipher fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;

  localparam int CLK_PERIOD_NS = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int LIMIT_CYCLES  = 2_000_000;
  // Longest item: 127 rounds plus load and write-back, with some margin.
  localparam int TAIL_CYCLES   = 160;
  localparam int HOLD_CYCLES   = 600;
  localparam int NUM_PHASES    = 12;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One input block as it crosses the input channel.
  typedef struct packed {
    logic        decrypt;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [3:0]  nbytes;
  } tea_block_t;

  // The two words of one result transfer.
  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
  } tea_words_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the cipher. Every input of the cipher
  // starts at a known value through its declaration.
  // --------------------------------------------------------------------------
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;

  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              req_type_i    = 1'b0;
  logic [31:0]       block_word0_i = '0;
  logic [31:0]       block_word1_i = '0;
  logic [3:0]        valid_bytes_i = '0;

  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [31:0]       result_word0_o;
  logic [31:0]       result_word1_o;

  // --------------------------------------------------------------------------
  // Copy of the configuration registers. It changes only while the cipher is
  // idle, so the copy that the driver sees at a transfer is the one in force.
  // --------------------------------------------------------------------------
  logic [31:0]        key_mirror [4] = '{default: '0};
  logic [ROUND_W-1:0] rounds_mirror  = 7'd32;
  logic               swap_mirror    = 1'b0;

  // Blocks waiting to be driven, and the results that accepted blocks owe.
  tea_block_t  blocks_to_send [$];
  tea_words_t  expected_words [$];
  tea_block_t  cur_block;

  // The counters only grow. A process that reads one in the same step as
  // its update sees the old value and simply keeps waiting.
  int unsigned blocks_queued    = 0;
  int unsigned blocks_accepted  = 0;
  int unsigned results_checked  = 0;
  int unsigned mismatch_cnt     = 0;
  int unsigned decrypt_cnt      = 0;
  int unsigned short_cnt        = 0;
  int unsigned configs_written  = 0;

  // Idling percentages, set per phase by the stimulus process.
  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;

  // The long output hold-off runs in a process of its own.
  logic        hold_start       = 1'b0;
  int unsigned hold_left        = 0;

  // Round-trip support: the ciphertext of the latest full encrypt block.
  tea_words_t  last_cipher;
  logic        have_cipher      = 1'b0;

  tea_block_cipher DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .block_word0_i  (block_word0_i),
    .block_word1_i  (block_word1_i),
    .valid_bytes_i  (valid_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_word0_o (result_word0_o),
    .result_word1_o (result_word1_o)
  );

  initial begin
    forever #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // TEA prediction.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = v[8*(3-i) +: 8];
    end
    return r;
  endfunction

  // The Feistel term of one half-round: shifted copies of one word mixed
  // with the running sum and a key pair.
  function automatic logic [31:0] round_term(input logic [31:0] w,
                                             input logic [31:0] sum,
                                             input logic [31:0] kl,
                                             input logic [31:0] kr);
    return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
  endfunction

  // Result of one block under the current configuration copy.
  function automatic tea_words_t cipher_words(input tea_block_t blk);
    tea_words_t  res;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    logic [31:0] nrounds;
    logic [31:0] k [4];
    // A short block passes through untouched, with no byte swap either.
    if (blk.nbytes < 4'd8) begin
      res.word0 = blk.word0;
      res.word1 = blk.word1;
      return res;
    end
    y = swap_mirror ? byte_rev(blk.word0) : blk.word0;
    z = swap_mirror ? byte_rev(blk.word1) : blk.word1;
    for (int i = 0; i < 4; i++) begin
      k[i] = swap_mirror ? byte_rev(key_mirror[i]) : key_mirror[i];
    end
    nrounds = {25'd0, rounds_mirror};
    if (!blk.decrypt) begin
      sum = '0;
      for (int r = 0; r < rounds_mirror; r++) begin
        sum = sum + TEA_DELTA;
        y   = y + round_term(z, sum, k[0], k[1]);
        z   = z + round_term(y, sum, k[2], k[3]);
      end
    end else begin
      // Decryption starts from the sum that encryption ends with.
      sum = TEA_DELTA * nrounds;
      for (int r = 0; r < rounds_mirror; r++) begin
        z   = z - round_term(y, sum, k[2], k[3]);
        y   = y - round_term(z, sum, k[0], k[1]);
        sum = sum - TEA_DELTA;
      end
    end
    res.word0 = swap_mirror ? byte_rev(y) : y;
    res.word1 = swap_mirror ? byte_rev(z) : z;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  // Random data word, with zero, all ones and single set bits mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_block(input logic decrypt, input logic [31:0] w0,
                             input logic [31:0] w1, input logic [3:0] nbytes);
    tea_block_t blk;
    blk.decrypt = decrypt;
    blk.word0   = w0;
    blk.word1   = w1;
    blk.nbytes  = nbytes;
    blocks_to_send = {blocks_to_send, blk};
    blocks_queued++;
  endtask

  // Mostly full blocks with random content. Some decrypt the latest
  // ciphertext, so that round trips are exercised, and some carry a
  // random byte count, short or oversized.
  task automatic queue_random_block();
    tea_block_t  blk;
    int unsigned roll;
    roll = $urandom_range(15);
    blk.decrypt = 1'($urandom_range(1));
    blk.word0   = pick_word();
    blk.word1   = pick_word();
    blk.nbytes  = ($urandom_range(99) < 70) ? 4'd8 : roll[3:0];
    if (have_cipher && $urandom_range(99) < 15) begin
      blk.decrypt = 1'b1;
      blk.word0   = last_cipher.word0;
      blk.word1   = last_cipher.word1;
      blk.nbytes  = 4'd8;
    end else if (!blk.decrypt && blk.nbytes >= 4'd8) begin
      last_cipher = cipher_words(blk);
      have_cipher = 1'b1;
    end
    queue_block(blk.decrypt, blk.word0, blk.word1, blk.nbytes);
  endtask

  // One register write: a setup phase, then an access phase that completes
  // at the edge where pready is seen high.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KEY0:   key_mirror[0] = value;
      REG_KEY1:   key_mirror[1] = value;
      REG_KEY2:   key_mirror[2] = value;
      REG_KEY3:   key_mirror[3] = value;
      REG_ROUNDS: rounds_mirror = value[ROUND_W-1:0];
      REG_SWAP:   swap_mirror   = value[0];
      default:    ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3,
                            input logic [31:0] rounds, input logic swap);
    apb_write(REG_KEY0, k0);
    apb_write(REG_KEY1, k1);
    apb_write(REG_KEY2, k2);
    apb_write(REG_KEY3, k3);
    apb_write(REG_ROUNDS, rounds);
    apb_write(REG_SWAP, {31'd0, swap});
    configs_written++;
    // Round trips only make sense under the key that made the ciphertext.
    have_cipher = 1'b0;
  endtask

  // Wait until every queued block has made its transfer and every result
  // has been checked. A short pause follows so that the cipher is idle
  // before any register write.
  task automatic wait_drained();
    while (blocks_accepted != blocks_queued || results_checked != blocks_accepted)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 55 : (mode == IDLE_BOTH) ? 9 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 55 : (mode == IDLE_BOTH) ? 9 : 0;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %08h, got %08h", $realtime, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A transfer happens at an edge where valid is high and
  // stall is low. The block that made the transfer is predicted right there,
  // with the configuration in force. A new block, or an idle cycle, is only
  // chosen once the current one has gone; a stalled block is held as it is.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_words = {expected_words, cipher_words(cur_block)};
        blocks_accepted++;
        if (cur_block.decrypt) decrypt_cnt++;
        if (cur_block.nbytes < 4'd8) short_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_block      = blocks_to_send.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= cur_block.decrypt;
          block_word0_i <= cur_block.word0;
          block_word1_i <= cur_block.word1;
          valid_bytes_i <= cur_block.nbytes;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor. Each result transfer is matched against the oldest
  // expectation, one word at a time. The stall for the next cycle is drawn
  // here too, forced high while the long hold-off runs.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tea_words_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected result word0", '0, result_word0_o);
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (result_word0_o !== want.word0)
            note_mismatch("result_word0", want.word0, result_word0_o);
          if (result_word1_o !== want.word1)
            note_mismatch("result_word1", want.word1, result_word1_o);
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The long hold-off: a countdown started by a one-cycle pulse.
  always @(posedge clk_i) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // Run limit. It lies far beyond the slowest correct run: every block at
  // 127 rounds, with the longest gaps and stalls on both sides.
  // --------------------------------------------------------------------------
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // Per phase: round count (-1 draws one from 1 to 64), swap flag, blocks.
    int          phase_rounds [NUM_PHASES] = '{32, 16, 1, 64, 0, 127, 2, -1, 32, -1, 8, 48};
    logic        phase_swap   [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1};
    int          phase_items  [NUM_PHASES] = '{150, 150, 150, 150, 100, 50,
                                               150, 150, 150, 150, 150, 100};
    int unsigned nrounds;
    logic [31:0] keys [4];
    tea_block_t  probe;
    tea_words_t  cipher;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset values: zero key, 32 rounds, no byte swap.
    queue_block(1'b0, 32'h0000_0000, 32'h0000_0000, 4'd8);
    queue_block(1'b1, 32'h0000_0000, 32'h0000_0000, 4'd8);
    queue_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8);
    wait_drained();

    // Extreme key words at the default round count. A known block is
    // encrypted and its ciphertext decrypted again.
    set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5, 32'h1234_5678, 32'd32, 1'b0);
    probe  = '{decrypt: 1'b0, word0: 32'h0123_4567, word1: 32'h89AB_CDEF, nbytes: 4'd8};
    cipher = cipher_words(probe);
    queue_block(1'b0, probe.word0, probe.word1, 4'd8);
    queue_block(1'b1, cipher.word0, cipher.word1, 4'd8);
    // Short blocks pass through; oversized counts act as full blocks.
    queue_block(1'b0, pick_word(), pick_word(), 4'd0);
    queue_block(1'b1, pick_word(), pick_word(), 4'd7);
    queue_block(1'b0, pick_word(), pick_word(), 4'd1);
    queue_block(1'b1, pick_word(), pick_word(), 4'd15);
    queue_block(1'b0, pick_word(), pick_word(), 4'd9);
    queue_block(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 4'd8);
    queue_block(1'b1, 32'h8000_0000, 32'h0000_0001, 4'd8);
    wait_drained();

    // Sixteen rounds with byte swap; a short block is not swapped at all.
    set_config($urandom, $urandom, $urandom, $urandom, 32'd16, 1'b1);
    cipher = cipher_words(probe);
    queue_block(1'b0, probe.word0, probe.word1, 4'd8);
    queue_block(1'b1, probe.word0, probe.word1, 4'd8);
    queue_block(1'b1, cipher.word0, cipher.word1, 4'd8);
    queue_block(1'b0, 32'h0011_2233, 32'h4455_6677, 4'd4);
    wait_drained();

    // Zero rounds: the block returns as it came, the two swaps cancelling.
    set_config($urandom, $urandom, $urandom, $urandom, 32'd0, 1'b1);
    queue_block(1'b0, pick_word(), pick_word(), 4'd8);
    queue_block(1'b1, pick_word(), pick_word(), 4'd8);
    wait_drained();

    // The largest round count the register holds.
    set_config($urandom, $urandom, $urandom, $urandom, 32'd127, 1'b0);
    queue_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8);
    queue_block(1'b1, 32'h0000_0000, 32'h0000_0000, 4'd8);
    wait_drained();

    // Random phases. The idling pattern rotates through all four modes, so
    // gaps and stalls fall on every stage of the round loop.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < 4; i++)
        keys[i] = (p % 4 == 3) ? 32'hFFFF_FFFF : $urandom;
      nrounds = (phase_rounds[p] < 0) ? $urandom_range(64, 1) : phase_rounds[p];
      set_config(keys[0], keys[1], keys[2], keys[3], nrounds, phase_swap[p]);
      set_idling(idle_mode_e'(p % 4));
      if (p == 8) begin
        // Hold the output off while blocks keep coming, so that the cipher
        // fills and pushes back on its input.
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      for (int n = 0; n < phase_items[p]; n++)
        queue_random_block();
      wait_drained();
    end

    set_idling(IDLE_NONE);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $display("%0d expected results never arrived", expected_words.size());
      mismatch_cnt += expected_words.size();
    end

    $display("Covered %0d blocks (%0d decrypts, %0d short) over %0d register settings,",
             blocks_accepted, decrypt_cnt, short_cnt, configs_written);
    $display("rounds 0 to 127, both byte orders, four idling patterns; %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
